>>> rtl/slfr_pkg.sv
// Shared types, codes and constants for the serial link frame receiver.
// No dependencies; imported by every module of the block.
package slfr_pkg;

	localparam int DATA_LIMIT    = 255;
	localparam int HANDSHAKE_MAX = 8;
	localparam int QDEPTH        = 4;

	typedef enum logic [1:0] {
		A_BYTE    = 2'd0,
		A_TIMEOUT = 2'd1,
		A_LOST    = 2'd2,
		A_RELEASE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		K_PAYLOAD = 3'd0,
		K_ACCEPT  = 3'd1,
		K_REJECT  = 3'd2,
		K_UP      = 3'd3,
		K_DOWN    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		T_DEBUG  = 2'd0,
		T_DATA   = 2'd1,
		T_STREAM = 2'd2
	} ftype_t;

	typedef enum logic [2:0] {
		E_NONE   = 3'd0,
		E_SUM    = 3'd1,
		E_DOUBLE = 3'd2,
		E_LOST   = 3'd3,
		E_LONG   = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		PH_CMD     = 3'd0,
		PH_LEN     = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CS_HI   = 3'd4,
		PH_CS_LO   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		CFG_HS_BYTES     = 3'd0,
		CFG_HS_LENGTH    = 3'd1,
		CFG_CODE_DEBUG   = 3'd2,
		CFG_CODE_DATA    = 3'd3,
		CFG_CODE_STREAM  = 3'd4,
		CFG_REPLY_FLAG   = 3'd5,
		CFG_STREAM_LIMIT = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [63:0] hs_bytes;
		logic [3:0]  hs_length;
		logic [7:0]  code_debug;
		logic [7:0]  code_data;
		logic [7:0]  code_stream;
		logic [7:0]  reply_flag;
		logic [15:0] stream_limit;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		ftype_t      ftype;
		logic [7:0]  value;
		err_t        err;
		logic        last;
	} res_t;

	typedef struct packed {
		logic                          room;
		logic [$clog2(QDEPTH+1)-1:0]   count;
	} qstat_t;

endpackage

>>> rtl/slfr_core.sv
// Deframer state and combinational step logic: handshake match, frame phases, checksum.
// Depends on slfr_pkg; emits up to two results per transaction.
module slfr_core import slfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  action_t    act,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output logic [1:0] n,
	output res_t       r0,
	output res_t       r1
);

	typedef struct packed {
		logic        link_up;
		logic [3:0]  match_pos;
		phase_t      phase;
		ftype_t      cur_type;
		logic [7:0]  len_hi;
		logic [15:0] bytes_left;
		logic [15:0] sum;
		logic [7:0]  cs_hi;
		logic        held;
	} st_t;

	localparam st_t ST_RESET = '{
		link_up: 1'b0, match_pos: 4'd0, phase: PH_CMD, cur_type: T_DEBUG,
		len_hi: 8'd0, bytes_left: 16'd0, sum: 16'd0, cs_hi: 8'd0, held: 1'b0
	};

	st_t         st_q;
	st_t         nx;
	logic [3:0]  hs_len;
	logic [3:0]  pos;
	logic [7:0]  want;
	logic [3:0]  pos_nx;
	logic [15:0] len16;
	logic [15:0] bl_dec;
	logic        do_drop;
	logic        drop_clr;
	err_t        drop_err;
	logic        do_accept;
	logic [7:0]  ack_code;
	res_t        ra;
	res_t        rb;

	always_comb begin
		if (cfg.hs_length == 4'd0)
			hs_len = 4'd1;
		else if (cfg.hs_length > 4'(HANDSHAKE_MAX))
			hs_len = 4'(HANDSHAKE_MAX);
		else
			hs_len = cfg.hs_length;
		pos  = (st_q.match_pos >= hs_len) ? 4'd0 : st_q.match_pos;
		want = cfg.hs_bytes[{pos[2:0], 3'b000} +: 8];
		if (rx_byte == want)
			pos_nx = pos + 4'd1;
		else
			pos_nx = (rx_byte == cfg.hs_bytes[7:0]) ? 4'd1 : 4'd0;
	end

	assign len16  = {st_q.len_hi, rx_byte};
	assign bl_dec = (st_q.bytes_left != 16'd0) ? st_q.bytes_left - 16'd1 : 16'd0;

	always_comb begin
		unique case (st_q.cur_type)
			T_DEBUG: ack_code = cfg.code_debug;
			T_DATA:  ack_code = cfg.code_data;
			default: ack_code = cfg.code_stream;
		endcase
	end

	always_comb begin
		nx        = st_q;
		n         = 2'd0;
		ra        = '0;
		rb        = '0;
		do_drop   = 1'b0;
		drop_clr  = 1'b0;
		drop_err  = E_NONE;
		do_accept = 1'b0;
		case (act)
			A_BYTE: begin
				if (!st_q.link_up) begin
					nx.match_pos = pos_nx;
					if (pos_nx == hs_len) begin
						nx.match_pos  = 4'd0;
						nx.link_up    = 1'b1;
						nx.phase      = PH_CMD;
						nx.cur_type   = T_DEBUG;
						nx.len_hi     = 8'd0;
						nx.bytes_left = 16'd0;
						nx.sum        = 16'd0;
						nx.cs_hi      = 8'd0;
						ra            = '{K_UP, T_DEBUG, 8'd0, E_NONE, 1'b0};
						n             = 2'd1;
					end
				end else begin
					unique case (st_q.phase)
						PH_CMD: begin
							if (rx_byte == cfg.code_debug) begin
								nx.cur_type = T_DEBUG;
								nx.phase    = PH_LEN;
							end else if (rx_byte == cfg.code_data) begin
								if (st_q.held) begin
									ra       = '{K_REJECT, T_DATA, 8'd0, E_DOUBLE, 1'b0};
									n        = 2'd1;
									do_drop  = 1'b1;
									drop_clr = 1'b1;
									drop_err = E_DOUBLE;
								end else begin
									nx.cur_type = T_DATA;
									nx.phase    = PH_LEN;
								end
							end else if (rx_byte == cfg.code_stream) begin
								nx.cur_type = T_STREAM;
								nx.phase    = PH_LEN;
							end
						end
						PH_LEN: begin
							if (st_q.cur_type == T_STREAM) begin
								nx.len_hi = rx_byte;
								nx.phase  = PH_LEN_LO;
							end else if (st_q.cur_type == T_DATA &&
								rx_byte > 8'(DATA_LIMIT)) begin
								ra = '{K_REJECT, T_DATA, 8'd0, E_LONG, 1'b0};
								n  = 2'd1;
								nx = '{link_up: st_q.link_up, match_pos: st_q.match_pos,
									phase: PH_CMD, cur_type: T_DEBUG, len_hi: 8'd0,
									bytes_left: 16'd0, sum: 16'd0, cs_hi: 8'd0,
									held: st_q.held};
							end else begin
								nx.bytes_left = {8'd0, rx_byte};
								nx.sum        = 16'd0;
								if (rx_byte != 8'd0)
									nx.phase = PH_PAYLOAD;
								else if (st_q.cur_type == T_DEBUG)
									do_accept = 1'b1;
								else
									nx.phase = PH_CS_HI;
							end
						end
						PH_LEN_LO: begin
							if (len16 > cfg.stream_limit) begin
								ra = '{K_REJECT, T_STREAM, 8'd0, E_LONG, 1'b0};
								n  = 2'd1;
								nx = '{link_up: st_q.link_up, match_pos: st_q.match_pos,
									phase: PH_CMD, cur_type: T_DEBUG, len_hi: 8'd0,
									bytes_left: 16'd0, sum: 16'd0, cs_hi: 8'd0,
									held: st_q.held};
							end else begin
								nx.bytes_left = len16;
								nx.sum        = 16'd0;
								if (len16 != 16'd0)
									nx.phase = PH_PAYLOAD;
								else if (st_q.cur_type == T_DEBUG)
									do_accept = 1'b1;
								else
									nx.phase = PH_CS_HI;
							end
						end
						PH_PAYLOAD: begin
							ra = '{K_PAYLOAD, st_q.cur_type, rx_byte, E_NONE, 1'b0};
							n  = 2'd1;
							nx.sum        = st_q.sum + {8'd0, rx_byte};
							nx.bytes_left = bl_dec;
							if (bl_dec == 16'd0) begin
								if (st_q.cur_type == T_DEBUG)
									do_accept = 1'b1;
								else
									nx.phase = PH_CS_HI;
							end
						end
						PH_CS_HI: begin
							nx.cs_hi = rx_byte;
							nx.phase = PH_CS_LO;
						end
						PH_CS_LO: begin
							if ({st_q.cs_hi, rx_byte} != st_q.sum) begin
								do_drop  = 1'b1;
								drop_clr = 1'b1;
								drop_err = E_SUM;
							end else begin
								do_accept = 1'b1;
							end
						end
						default: begin
							nx.phase      = PH_CMD;
							nx.cur_type   = T_DEBUG;
							nx.len_hi     = 8'd0;
							nx.bytes_left = 16'd0;
							nx.sum        = 16'd0;
							nx.cs_hi      = 8'd0;
						end
					endcase
				end
			end
			A_TIMEOUT: begin
				if (st_q.link_up && st_q.phase != PH_CMD) begin
					do_drop  = 1'b1;
					drop_clr = 1'b1;
					drop_err = E_LOST;
				end
			end
			A_LOST: begin
				if (st_q.link_up) begin
					do_drop  = 1'b1;
					drop_clr = (st_q.phase != PH_CMD);
					drop_err = E_LOST;
				end
			end
			default: begin
				nx.held = 1'b0;
			end
		endcase

		if (do_accept) begin
			if (n == 2'd0)
				ra = '{K_ACCEPT, st_q.cur_type, ack_code | cfg.reply_flag, E_NONE, 1'b0};
			else
				rb = '{K_ACCEPT, st_q.cur_type, ack_code | cfg.reply_flag, E_NONE, 1'b0};
			n = n + 2'd1;
			if (st_q.cur_type == T_DATA)
				nx.held = 1'b1;
			nx.phase      = PH_CMD;
			nx.cur_type   = T_DEBUG;
			nx.len_hi     = 8'd0;
			nx.bytes_left = 16'd0;
			nx.sum        = 16'd0;
			nx.cs_hi      = 8'd0;
		end

		if (do_drop) begin
			if (st_q.phase != PH_CMD) begin
				ra = '{K_REJECT, st_q.cur_type, 8'd0, drop_err, 1'b0};
				rb = '{K_DOWN, T_DEBUG, 8'd0, drop_err, 1'b0};
				n  = 2'd2;
			end else if (n == 2'd0) begin
				ra = '{K_DOWN, T_DEBUG, 8'd0, drop_err, 1'b0};
				n  = 2'd1;
			end else begin
				rb = '{K_DOWN, T_DEBUG, 8'd0, drop_err, 1'b0};
				n  = 2'd2;
			end
			nx.phase      = PH_CMD;
			nx.cur_type   = T_DEBUG;
			nx.len_hi     = 8'd0;
			nx.bytes_left = 16'd0;
			nx.sum        = 16'd0;
			nx.cs_hi      = 8'd0;
			nx.link_up    = 1'b0;
			nx.match_pos  = 4'd0;
			if (drop_clr)
				nx.held = 1'b0;
		end
	end

	always_comb begin
		r0 = ra;
		r1 = rb;
		if (n == 2'd1)
			r0.last = 1'b1;
		if (n == 2'd2)
			r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_RESET;
		else if (fire)
			st_q <= nx;
	end

endmodule

>>> rtl/slfr_outq.sv
// Result queue: takes zero, one or two results per cycle, drains one per cycle on ready.
// Depends on slfr_pkg for the result type and queue depth.
module slfr_outq import slfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push,
	input  res_t       r0,
	input  res_t       r1,
	output logic       valid,
	input  logic       ready,
	output res_t       head,
	output qstat_t     stat
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	res_t          mem_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wp1;
	logic          pop;

	assign wp1        = wp_q + PW'(1);
	assign valid      = (count_q != CW'(0));
	assign pop        = valid && ready;
	assign head       = mem_q[rp_q];
	assign stat.count = count_q;
	assign stat.room  = (count_q <= CW'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push != 2'd0)
			mem_q[wp_q] <= r0;
		if (push == 2'd2)
			mem_q[wp1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PW'(push);
			rp_q    <= rp_q + PW'(pop);
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

>>> rtl/serial_link_frame_receiver_top.sv
// Top level of the serial link frame receiver: input register, configuration registers,
// step logic and result queue. Depends on slfr_pkg, slfr_core and slfr_outq.

// Takes one event per cycle while the result queue has room (received byte, read
// timeout, link loss or consumer release) and produces zero, one or two results per event.
// Events pass through the input register; their results are written into the result
// queue and offered on the master side in order. The step logic advances only when the
// four-entry result queue has room for two results, so sustained input rate is one event
// per cycle while the master side drains one result per cycle; events that yield two
// results fill two queue entries. The user must write configuration through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not enforce this.
module serial_link_frame_receiver_top import slfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] value, [10:8] error_code, [15:11] zero
	output logic [4:0]  m_tuser,   // [2:0] kind, [4:3] frame_type
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	action_t    act_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic [1:0] n;
	res_t       r0;
	res_t       r1;
	res_t       head;
	qstat_t     stat;

	assign fire     = valid_s1 && stat.room;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1  <= action_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hs_bytes     <= 64'd0;
			cfg_q.hs_length    <= 4'd8;
			cfg_q.code_debug   <= 8'd1;
			cfg_q.code_data    <= 8'd2;
			cfg_q.code_stream  <= 8'd3;
			cfg_q.reply_flag   <= 8'd128;
			cfg_q.stream_limit <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HS_BYTES:     cfg_q.hs_bytes     <= cfg_data;
				CFG_HS_LENGTH:    cfg_q.hs_length    <= cfg_data[3:0];
				CFG_CODE_DEBUG:   cfg_q.code_debug   <= cfg_data[7:0];
				CFG_CODE_DATA:    cfg_q.code_data    <= cfg_data[7:0];
				CFG_CODE_STREAM:  cfg_q.code_stream  <= cfg_data[7:0];
				CFG_REPLY_FLAG:   cfg_q.reply_flag   <= cfg_data[7:0];
				CFG_STREAM_LIMIT: cfg_q.stream_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	slfr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.act     (act_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.n       (n),
		.r0      (r0),
		.r1      (r1)
	);

	slfr_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire ? n : 2'd0),
		.r0     (r0),
		.r1     (r1),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.head   (head),
		.stat   (stat)
	);

	assign m_tdata = {5'd0, head.err, head.value};
	assign m_tuser = {head.ftype, head.kind};
	assign m_tlast = head.last;

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(stat.count) <= QDEPTH)
		else $error("result queue overflow");

	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && n == 2'd2) |-> (!r0.last && r1.last))
		else $error("last flag on wrong result");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && n == 2'd1) |-> r0.last)
		else $error("single result without last");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !stat.room) |=> valid_s1)
		else $error("input item lost while queue full");
`endif

endmodule
